// ----- hw/rtl/spbmd_pkg.sv -----
// ----------------------------------------------------------------------------
// spbmd_pkg: shared types and constants of the sector-priority drain.
// Holds default sizes, result codes and the controller command structs.
// ----------------------------------------------------------------------------
package spbmd_pkg;

  localparam int NumBusesDefault   = 512;
  localparam int HalfSectorDefault = 7;
  localparam int QueueDepthDefault = 16;

  localparam int WordW   = 62;
  localparam int DropW   = 32;
  localparam int LimitW  = 5;
  localparam int HitW    = 30;
  localparam int SecNumW = 6;

  localparam logic [1:0] KIND_STORED  = 2'd0;
  localparam logic [1:0] KIND_DROPPED = 2'd1;
  localparam logic [1:0] KIND_READOUT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;  // clear one bus entry of the fill/head tables
    logic wr_look;     // read fill/head of the write bus
    logic wr_commit;   // store or drop the hit
    logic scan_step;   // visit one bus while counting sectors
    logic scan_start;  // reset counting state
    logic drain_start; // set the drain bus to the first of the chosen sector
    logic drain_look;  // read fill/head/entry of the drain bus
    logic drain_step;  // pop the drain bus and shift its nibble in
    logic finish;      // append the sector number
  } spbmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic best_zero;
    logic drain_last;
  } spbmd_stat_t;

endpackage

// ----- hw/rtl/spbmd_datapath.sv -----
// ----------------------------------------------------------------------------
// spbmd_datapath: bus tables, queue memory, sector counters and readout word.
// All tables are memories read one address a cycle with registered data.
// ----------------------------------------------------------------------------
module spbmd_datapath
  import spbmd_pkg::*;
#(
  parameter int NUM_BUSES   = NumBusesDefault,
  parameter int HALF_SECTOR = HalfSectorDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  spbmd_cmd_t          cmd,
  output spbmd_stat_t         stat,
  input  logic [HitW-1:0]     hit_word,
  input  logic [LimitW-1:0]   limit,
  output logic                drop_flag,
  output logic [WordW-1:0]    word,
  output logic [DropW-1:0]    drop_count
);

  localparam int SecLen  = 2 * HALF_SECTOR;
  localparam int NumSec  = (NUM_BUSES + SecLen - 1) / SecLen;
  localparam int BusW    = $clog2(NUM_BUSES);
  localparam int PtrW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SecW    = (NumSec > 1) ? $clog2(NumSec) : 1;
  localparam int CntW    = $clog2(SecLen + 1);
  localparam int OffW    = $clog2(SecLen);
  localparam int MemW    = BusW + PtrW;
  localparam int DepthW  = $clog2(QUEUE_DEPTH + 1);

  // Fill and head tables, one entry per bus.
  logic [FillW-1:0] fill_mem [NUM_BUSES];
  logic [PtrW-1:0]  head_mem [NUM_BUSES];
  logic [3:0]       queue_mem [1 << MemW];

  logic [BusW-1:0]  bus;       // current table address
  logic [FillW-1:0] fill_rd;
  logic [PtrW-1:0]  head_rd;
  logic [3:0]       nib_rd;
  logic [SecW-1:0]  sec;       // sector under count
  logic [OffW-1:0]  off;       // bus offset within sector
  logic [CntW-1:0]  cnt;
  logic [CntW-1:0]  best_cnt;
  logic [SecW-1:0]  best;
  logic [WordW-1:0] acc;
  logic [DropW-1:0] drops;
  logic             drop_flag_r;
  logic             scan_first;

  // Write bus from the hit word; out of range goes to a drop.
  logic [9:0] wbus;
  logic       wbus_ok;
  logic [4:0] pop;
  logic [FillW-1:0] lim;
  logic [DepthW-1:0] qd;
  logic [PtrW-1:0] slot;
  logic [PtrW:0]   slot_sum;
  logic [BusW-1:0] sec_base;

  always_comb begin
    wbus = hit_word[8] ? {1'b0, hit_word[7:0], 1'b0} : {2'b00, hit_word[7:0]};
    wbus_ok = ({22'd0, wbus} < 32'(NUM_BUSES));
    pop = '0;
    for (int i = 0; i < 16; i++) begin
      pop = pop + 5'(hit_word[14 + i]);
    end
    qd = DepthW'(QUEUE_DEPTH);
    if (32'(limit) > 32'(QUEUE_DEPTH)) begin
      lim = FillW'(qd);
    end else begin
      lim = FillW'(limit);
    end
    slot_sum = (PtrW + 1)'(head_rd) + (PtrW + 1)'(fill_rd);
    if (32'(slot_sum) >= 32'(QUEUE_DEPTH)) begin
      slot = PtrW'(32'(slot_sum) - 32'(QUEUE_DEPTH));
    end else begin
      slot = PtrW'(slot_sum);
    end
    sec_base = BusW'(32'(best) * SecLen);
  end

  // Registered table reads at the current bus; the entry uses the registered head.
  always_ff @(posedge clk) begin
    fill_rd <= fill_mem[bus];
    head_rd <= head_mem[bus];
    nib_rd  <= queue_mem[{bus, head_rd}];
  end

  // Table writes: clearing sweep, hit store and drain pop.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      fill_mem[bus] <= '0;
      head_mem[bus] <= '0;
    end else if (cmd.wr_commit && !drop_flag_r && fill_rd < lim) begin
      fill_mem[bus] <= fill_rd + FillW'(1);
      queue_mem[MemW'({bus, slot})] <= pop[3:0];
    end else if (cmd.drain_step && fill_rd != '0) begin
      fill_mem[bus] <= fill_rd - FillW'(1);
      head_mem[bus] <= (32'(head_rd) == QUEUE_DEPTH - 1) ? '0 : head_rd + PtrW'(1);
    end
  end

  // Address, counters and readout accumulation.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus <= '0;
      drops <= '0;
      drop_flag_r <= 1'b0;
      scan_first <= 1'b0;
      sec <= '0; off <= '0; cnt <= '0; best_cnt <= '0; best <= '0; acc <= '0;
    end else begin
      if (cmd.clear_step) begin
        bus <= bus + BusW'(1);
      end
      if (cmd.wr_look) begin
        bus <= wbus[BusW-1:0];
        drop_flag_r <= !wbus_ok;
        acc <= '0;
      end
      if (cmd.wr_commit) begin
        if (drop_flag_r || fill_rd >= lim) begin
          drop_flag_r <= 1'b1;
          if (drops != '1) drops <= drops + DropW'(1);
        end
      end
      if (cmd.scan_start) begin
        bus <= '0; sec <= '0; off <= '0; cnt <= '0; best_cnt <= '0; best <= '0;
        acc <= '0;
        scan_first <= 1'b1;
      end
      if (cmd.scan_step) begin
        // The first step only moves the address; after it, fill_rd belongs to bus-1.
        if (scan_first) begin
          scan_first <= 1'b0;
        end else if (32'(off) == SecLen - 1 || bus == BusW'(NUM_BUSES)) begin
          if (cnt + CntW'(fill_rd != '0) > best_cnt) begin
            best_cnt <= cnt + CntW'(fill_rd != '0);
            best <= sec;
          end
          cnt <= '0; off <= '0; sec <= sec + SecW'(1);
        end else begin
          cnt <= cnt + CntW'(fill_rd != '0);
          off <= off + OffW'(1);
        end
        bus <= bus + BusW'(1);
      end
      if (cmd.drain_start) begin
        bus <= sec_base; off <= '0;
      end
      if (cmd.drain_step) begin
        acc <= {acc[WordW-5:0], (fill_rd != '0) ? nib_rd : 4'd0};
        bus <= bus + BusW'(1);
        off <= off + OffW'(1);
      end
      if (cmd.finish) begin
        acc <= {acc[WordW-SecNumW-1:0], SecNumW'(32'(best) & 32'h3F)};
      end
    end
  end

  assign stat.clear_last = (32'(bus) == NUM_BUSES - 1);
  assign stat.scan_last  = !scan_first && (32'(bus) == NUM_BUSES - 1);
  assign stat.best_zero  = (best_cnt == '0);
  assign stat.drain_last = (32'(off) == SecLen - 1) ||
                           (32'(bus) == NUM_BUSES - 1);
  assign drop_flag  = drop_flag_r;
  assign word       = acc;
  assign drop_count = drops;

endmodule

// ----- hw/rtl/spbmd_ctrl.sv -----
// ----------------------------------------------------------------------------
// spbmd_ctrl: sequencer for clearing, hit stores and sector drains.
// Issues one datapath command per cycle and owns the handshakes.
// ----------------------------------------------------------------------------
module spbmd_ctrl
  import spbmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  input  logic        drop_flag,
  input  spbmd_stat_t stat,
  output spbmd_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WLOOK  = 4'd2;
  localparam logic [3:0] S_WCOMM  = 4'd3;
  localparam logic [3:0] S_SPRIME = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_SDONE  = 4'd6;
  localparam logic [3:0] S_DADDR  = 4'd7;
  localparam logic [3:0] S_DLOOK  = 4'd8;
  localparam logic [3:0] S_DSTEP  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_WOUT   = 4'd12;
  localparam logic [3:0] S_DNIB   = 4'd13;

  logic [3:0] state, state_next;
  logic [1:0] kind_r, kind_next;

  always_comb begin
    state_next = state;
    kind_next = kind_r;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (func) begin
            cmd.scan_start = 1'b1;
            state_next = S_SPRIME;
          end else begin
            cmd.wr_look = 1'b1;
            state_next = S_WLOOK;
          end
        end
      end
      S_WLOOK: state_next = S_WCOMM;
      S_WCOMM: begin
        cmd.wr_commit = 1'b1;
        state_next = S_WOUT;
      end
      S_WOUT: begin
        kind_next = drop_flag ? KIND_DROPPED : KIND_STORED;
        state_next = S_OUT;
      end
      // Bus 0 read is in flight; start counting on the next cycle.
      S_SPRIME: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_SDONE;
      end
      S_SDONE: begin
        cmd.scan_step = 1'b1;
        state_next = S_DADDR;
      end
      S_DADDR: begin
        if (stat.best_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.drain_start = 1'b1;
          state_next = S_DLOOK;
        end
      end
      // Fill and head of the drain bus are read first, then its head entry.
      S_DLOOK: state_next = S_DNIB;
      S_DNIB:  state_next = S_DSTEP;
      S_DSTEP: begin
        cmd.drain_step = 1'b1;
        state_next = stat.drain_last ? S_FIN : S_DLOOK;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        kind_next = KIND_READOUT;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      kind_r <= KIND_STORED;
    end else begin
      state <= state_next;
      kind_r <= kind_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign kind      = (state == S_OUT) ? kind_r : KIND_STORED;

endmodule

// ----- hw/rtl/sector_priority_bus_memory_drain.sv -----
// ----------------------------------------------------------------------------
// sector_priority_bus_memory_drain: per-bus hit queues with sector readout.
// Stores hit popcounts per bus and drains the fullest sector on a read slot.
// ----------------------------------------------------------------------------
// After reset the block clears its bus tables, one bus entry at a time, and takes
// no item meanwhile. A hit transfer passes the look, commit and result states
// before the output transfer. A read slot scans every bus through the single
// read port of the fill table, then drains the chosen sector bus by bus (look,
// entry read, pop) and appends the sector number; a read slot with all buses
// empty gives no result.
module sector_priority_bus_memory_drain
  import spbmd_pkg::*;
#(
  parameter int NUM_BUSES   = NumBusesDefault,
  parameter int HALF_SECTOR = HalfSectorDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [HitW-1:0]   hit_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        result_kind,
  output logic [WordW-1:0]  readout_word,
  output logic [DropW-1:0]  dropped_total,
  input  logic              cfg_we,
  input  logic [LimitW-1:0] cfg_wdata
);

  spbmd_cmd_t      cmd;
  spbmd_stat_t     stat;
  logic            drop_flag;
  logic [LimitW-1:0] depth_limit;
  logic [HitW-1:0] hit_r;
  logic [WordW-1:0] word;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= LimitW'(16);
    end else if (cfg_we) begin
      depth_limit <= cfg_wdata;
    end
  end

  // Hit word held for the whole item.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hit_r <= hit_word;
  end

  spbmd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .func, .out_valid, .out_ready,
    .kind(result_kind), .drop_flag, .stat, .cmd
  );

  spbmd_datapath #(
    .NUM_BUSES(NUM_BUSES), .HALF_SECTOR(HALF_SECTOR), .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .hit_word(cmd.wr_look ? hit_word : hit_r),
    .limit(depth_limit), .drop_flag, .word, .drop_count(dropped_total)
  );

  assign readout_word = (result_kind == KIND_READOUT) ? word : '0;

  // A result is never offered while an item is being taken.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  // The drop total never decreases.
  assert property (@(posedge clk) disable iff (rst)
      $past(!rst) |-> dropped_total >= $past(dropped_total))
    else $error("drop total went down");
  // Store and drop results carry an all-zero readout word.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && result_kind != KIND_READOUT |-> readout_word == '0)
    else $error("readout word set on a hit result");

endmodule
